[design/sctd_pkg.sv]
// Shared types and codes for the sector cache tag directory.
// Holds request kinds, event codes, controller states and the per-entry command word.
// No dependencies; used by sctd_cell and sector_cache_tag_directory.
package sctd_pkg;

	// request kinds as carried in the slave word
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	// event codes of a result word
	typedef enum logic [1:0] {
		EV_DONE  = 2'd0,
		EV_WB    = 2'd1,
		EV_RANGE = 2'd2,
		EV_RO    = 2'd3
	} event_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REPL,
		ST_FLUSH
	} state_t;

	// configuration register indexes
	localparam logic CFG_READ_ONLY    = 1'b0;
	localparam logic CFG_SECTOR_LIMIT = 1'b1;

	localparam int unsigned TAG_W = 32;

	// command from the controller to one entry cell
	typedef struct packed {
		logic wr_tag;     // load the broadcast sector as new tag
		logic dirty_we;   // update the dirty bit
		logic dirty_val;  // value for the dirty bit
		logic clr_all;    // flush: drop the dirty bit
	} cell_cmd_t;

endpackage

[design/sctd_cell.sv]
// One entry of the tag directory: tag, dirty bit and a link of the match chain.
// The chain carries the first-match index from cell to cell along the row.
// Depends on sctd_pkg.
module sctd_cell #(
	parameter int unsigned IDX_W = 4,
	parameter int unsigned INDEX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic [sctd_pkg::TAG_W-1:0] sector,
	input  sctd_pkg::cell_cmd_t     cmd,
	input  logic                    found_i,
	input  logic [IDX_W-1:0]        idx_i,
	output logic                    found_o,
	output logic [IDX_W-1:0]        idx_o,
	output logic                    match,
	output logic [sctd_pkg::TAG_W-1:0] tag,
	output logic                    dirty
);

	logic [sctd_pkg::TAG_W-1:0] tag_q;
	logic                       dirty_q;

	// tag store, written only on allocation
	always_ff @(posedge clk) begin
		if (cmd.wr_tag) begin
			tag_q <= sector;
		end
	end

	// dirty bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
		end else if (cmd.clr_all) begin
			dirty_q <= 1'b0;
		end else if (cmd.dirty_we) begin
			dirty_q <= cmd.dirty_val;
		end
	end

	// compare and pass the first match on down the row
	assign match   = valid && (tag_q == sector);
	assign found_o = found_i || match;
	assign idx_o   = found_i ? idx_i : IDX_W'(INDEX);
	assign tag     = tag_q;
	assign dirty   = dirty_q;

endmodule

[design/sector_cache_tag_directory.sv]
// Top level of the sector cache tag directory: controller, config registers, output word.
// Builds a row of sctd_cell entries and walks them for victim and flush reads.
// Depends on sctd_pkg and sctd_cell.

// Fully associative tag directory with round-robin replacement. One request is
// taken at a time. A read or write is accepted, then looked up across the row
// of entry cells in ST_EVAL, with an ST_REPL step after it when a dirty victim is
// reported as a writeback first. A flush is accepted and decoded, then scans the
// valid entries in ST_FLUSH through the shared read port, one entry per cycle while
// no writeback waits on a full output register, then gives the final word. A new
// request is accepted while the final result still waits in the output
// register; a full output register holds the controller.
module sector_cache_tag_directory #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] kind, [33:2] sector, rest zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [1:0] event_res, [2] hit, [6:3] entry, [7] disk_read,
	                               // [8] disk_write, [40:9] wb_sector, rest zero
	output logic        m_tlast    // last
);

	localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned FILL_W = $clog2(ENTRIES + 1);
	localparam int unsigned TAG_W  = sctd_pkg::TAG_W;

	sctd_pkg::state_t state_q, state_d;

	// configuration registers
	logic             read_only_q;
	logic [TAG_W-1:0] limit_q;

	// request registers
	sctd_pkg::kind_t  kind_q;
	logic [TAG_W-1:0] sector_q;

	// policy state
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  victim_q;
	logic [FILL_W-1:0] scan_q;

	// output word
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic        m_tlast_q;
	logic        out_free;

	// cell row
	sctd_pkg::cell_cmd_t cmd     [ENTRIES];
	logic [TAG_W-1:0]    cell_tag[ENTRIES];
	logic [ENTRIES-1:0]  cell_dirty;
	logic [ENTRIES-1:0]  cell_match;
	logic [ENTRIES:0]    chain_found;
	logic [IDX_W-1:0]    chain_idx[ENTRIES+1];

	// decision signals
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic             is_write;
	logic             full;
	logic [IDX_W-1:0] rd_idx;
	logic [TAG_W-1:0] rd_tag;
	logic             rd_dirty;
	logic             scan_done;
	logic             victim_wb;

	// actions from the output block
	logic             alloc_we;
	logic [IDX_W-1:0] alloc_idx;
	logic             hit_wr;
	logic             flush_clr;
	logic             victim_adv;
	logic             fill_inc;
	logic             scan_inc;
	logic             emit;
	sctd_pkg::event_t emit_ev;
	logic             emit_hit;
	logic [IDX_W-1:0] emit_idx;
	logic             emit_rd;
	logic             emit_wr;
	logic [TAG_W-1:0] emit_wbs;
	logic             emit_last;
	logic [IDX_W+3:0] emit_idx_ext;

	assign s_tready = (state_q == sctd_pkg::ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// row of entry cells with the match chain running through it
	assign chain_found[0] = 1'b0;
	assign chain_idx[0]   = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic cell_valid;

		assign cell_valid = (fill_q > FILL_W'(i));

		always_comb begin
			cmd[i].wr_tag    = alloc_we && (alloc_idx == IDX_W'(i));
			cmd[i].dirty_we  = (alloc_we && (alloc_idx == IDX_W'(i)))
			                || (hit_wr && (hit_idx == IDX_W'(i)));
			cmd[i].dirty_val = is_write;
			cmd[i].clr_all   = flush_clr;
		end

		sctd_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid   (cell_valid),
			.sector  (sector_q),
			.cmd     (cmd[i]),
			.found_i (chain_found[i]),
			.idx_i   (chain_idx[i]),
			.found_o (chain_found[i+1]),
			.idx_o   (chain_idx[i+1]),
			.match   (cell_match[i]),
			.tag     (cell_tag[i]),
			.dirty   (cell_dirty[i])
		);
	end

	// lookup result and shared read port (victim or flush scan)
	assign hit       = chain_found[ENTRIES];
	assign hit_idx   = chain_idx[ENTRIES];
	assign is_write  = (kind_q == sctd_pkg::KIND_WRITE);
	assign full      = (fill_q == FILL_W'(ENTRIES));
	assign rd_idx    = (state_q == sctd_pkg::ST_FLUSH) ? scan_q[IDX_W-1:0] : victim_q;
	assign rd_tag    = cell_tag[rd_idx];
	assign rd_dirty  = cell_dirty[rd_idx];
	assign scan_done = (scan_q == fill_q);
	assign victim_wb = rd_dirty && !read_only_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sctd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = sctd_pkg::ST_EVAL;
				end
			end
			sctd_pkg::ST_EVAL: begin
				if (kind_q == sctd_pkg::KIND_FLUSH) begin
					state_d = sctd_pkg::ST_FLUSH;
				end else if (out_free) begin
					if ((kind_q == sctd_pkg::KIND_READ || is_write) && !(is_write && read_only_q)
					    && (sector_q < limit_q) && !hit && full && victim_wb) begin
						state_d = sctd_pkg::ST_REPL;
					end else begin
						state_d = sctd_pkg::ST_IDLE;
					end
				end
			end
			sctd_pkg::ST_REPL: begin
				if (out_free) begin
					state_d = sctd_pkg::ST_IDLE;
				end
			end
			sctd_pkg::ST_FLUSH: begin
				if (scan_done && out_free) begin
					state_d = sctd_pkg::ST_IDLE;
				end
			end
			default: state_d = sctd_pkg::ST_IDLE;
		endcase
	end

	// actions and result word
	always_comb begin
		alloc_we   = 1'b0;
		alloc_idx  = victim_q;
		hit_wr     = 1'b0;
		flush_clr  = 1'b0;
		victim_adv = 1'b0;
		fill_inc   = 1'b0;
		scan_inc   = 1'b0;
		emit       = 1'b0;
		emit_ev    = sctd_pkg::EV_DONE;
		emit_hit   = 1'b0;
		emit_idx   = '0;
		emit_rd    = 1'b0;
		emit_wr    = 1'b0;
		emit_wbs   = '0;
		emit_last  = 1'b1;
		unique case (state_q)
			sctd_pkg::ST_EVAL: begin
				if (out_free && kind_q != sctd_pkg::KIND_FLUSH) begin
					emit = 1'b1;
					priority if (kind_q != sctd_pkg::KIND_READ && !is_write) begin
						// unused kind code: plain done
						emit_ev = sctd_pkg::EV_DONE;
					end else if (is_write && read_only_q) begin
						emit_ev = sctd_pkg::EV_RO;
					end else if (sector_q >= limit_q) begin
						emit_ev = sctd_pkg::EV_RANGE;
					end else if (hit) begin
						hit_wr   = is_write;
						emit_hit = 1'b1;
						emit_idx = hit_idx;
						emit_wr  = is_write;
					end else if (!full) begin
						// fill the next free entry
						alloc_we  = 1'b1;
						alloc_idx = fill_q[IDX_W-1:0];
						fill_inc  = 1'b1;
						emit_idx  = fill_q[IDX_W-1:0];
						emit_rd   = !is_write;
						emit_wr   = is_write;
					end else if (victim_wb) begin
						// report the dirty victim first
						emit_ev   = sctd_pkg::EV_WB;
						emit_idx  = victim_q;
						emit_wbs  = rd_tag;
						emit_last = 1'b0;
					end else begin
						alloc_we   = 1'b1;
						victim_adv = 1'b1;
						emit_idx   = victim_q;
						emit_rd    = !is_write;
						emit_wr    = is_write;
					end
				end
			end
			sctd_pkg::ST_REPL: begin
				if (out_free) begin
					alloc_we   = 1'b1;
					victim_adv = 1'b1;
					emit       = 1'b1;
					emit_idx   = victim_q;
					emit_rd    = !is_write;
					emit_wr    = is_write;
				end
			end
			sctd_pkg::ST_FLUSH: begin
				if (scan_done) begin
					if (out_free) begin
						flush_clr = 1'b1;
						emit      = 1'b1;
					end
				end else if (victim_wb) begin
					if (out_free) begin
						scan_inc  = 1'b1;
						emit      = 1'b1;
						emit_ev   = sctd_pkg::EV_WB;
						emit_idx  = rd_idx;
						emit_wbs  = rd_tag;
						emit_last = 1'b0;
					end
				end else begin
					scan_inc = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign emit_idx_ext = {4'b0000, emit_idx};

	// controller state and policy registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sctd_pkg::ST_IDLE;
			fill_q   <= '0;
			victim_q <= '0;
			scan_q   <= '0;
		end else begin
			state_q <= state_d;
			if (flush_clr) begin
				fill_q   <= '0;
				victim_q <= '0;
			end else begin
				if (fill_inc) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				if (victim_adv) begin
					victim_q <= (victim_q == IDX_W'(ENTRIES - 1)) ? '0 : victim_q + IDX_W'(1);
				end
			end
			if (state_q == sctd_pkg::ST_EVAL) begin
				scan_q <= '0;
			end else if (scan_inc) begin
				scan_q <= scan_q + FILL_W'(1);
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q   <= sctd_pkg::kind_t'(s_tdata[1:0]);
			sector_q <= s_tdata[33:2];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_only_q <= 1'b0;
			limit_q     <= '1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				sctd_pkg::CFG_READ_ONLY:    read_only_q <= cfg_wdata[0];
				sctd_pkg::CFG_SECTOR_LIMIT: limit_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {7'b0, emit_wbs, emit_wr, emit_rd, emit_idx_ext[3:0], emit_hit,
			              emit_ev};
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	// valid entries never hold the same sector twice
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cell_match))
		else $error("duplicate tag among valid entries");

	// fill count stays within the entry row
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FILL_W'(ENTRIES))
		else $error("fill count beyond entry count");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n) s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while one is in progress");

	// a writeback is never the final word of a request
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == sctd_pkg::EV_WB) |-> !m_tlast)
		else $error("writeback marked last");
`endif

endmodule

[bench/sector_cache_tag_directory_tb.sv]
// Self-checking bench for sector_cache_tag_directory: random burst driver, stalling sink,
// and a shadow copy of the tag directory that predicts every result word in order.
// Depends on sctd_pkg and the RTL under design/.
module sector_cache_tag_directory_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ENTRY_COUNT = 16;
	localparam logic [1:0] KIND_SPARE = 2'd3;	// unused kind code
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LEN = 300;
	localparam int SETTLE = 8;
	localparam int SINK_FREE = 0;
	localparam int SINK_RANDOM = 1;
	localparam int SINK_PATTERN = 2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] sector;
	} sector_req_t;

	typedef struct {
		sctd_pkg::event_t ev_code;
		logic        hit;
		logic [3:0]  entry;
		logic        disk_rd;
		logic        disk_wr;
		logic [31:0] wb_sector;
		logic        is_last;
	} dir_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;

	sector_cache_tag_directory #(
		.ENTRIES(ENTRY_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// requests waiting to be offered, result words still owed by the block
	sector_req_t req_queue[$];
	dir_result_t due_results[$];

	// shadow directory and register copies
	logic [31:0] shadow_tag [ENTRY_COUNT];
	logic        shadow_dirty [ENTRY_COUNT] = '{default: 1'b0};
	int unsigned shadow_fill = 0;
	int unsigned shadow_victim = 0;
	logic        shadow_ro = 1'b0;
	logic [31:0] shadow_limit = '1;

	int          fail_count = 0;
	int          reqs_taken = 0;
	int          words_checked = 0;
	int          wb_words = 0;
	int          hit_words = 0;
	int          reg_writes = 0;
	int          cycle_count = 0;
	logic [31:0] pool_base = 32'h0000_1000;
	bit          sender_gapless = 1'b0;
	int          sink_mode = SINK_FREE;
	int          hold_asks = 0;

	function automatic void expect_word(sctd_pkg::event_t ev, logic h, int unsigned ent,
			logic rd, logic wr, logic [31:0] wb, logic fin);
		dir_result_t w;
		w.ev_code = ev;
		w.hit = h;
		w.entry = ent[3:0];
		w.disk_rd = rd;
		w.disk_wr = wr;
		w.wb_sector = wb;
		w.is_last = fin;
		due_results.insert(due_results.size(), w);
	endfunction

	// shadow directory: update state and queue the words one request causes
	function automatic void apply_request(sector_req_t r);
		int          hit_idx;
		int unsigned slot;
		int unsigned i;
		logic        is_wr;
		hit_idx = -1;
		is_wr = (r.kind == sctd_pkg::KIND_WRITE);
		if (r.kind == sctd_pkg::KIND_READ || r.kind == sctd_pkg::KIND_WRITE) begin
			if (is_wr && shadow_ro) begin
				expect_word(sctd_pkg::EV_RO, 1'b0, 0, 1'b0, 1'b0, '0, 1'b1);
			end else if (r.sector >= shadow_limit) begin
				expect_word(sctd_pkg::EV_RANGE, 1'b0, 0, 1'b0, 1'b0, '0, 1'b1);
			end else begin
				for (i = 0; i < shadow_fill; i++)
					if (hit_idx < 0 && shadow_tag[i] == r.sector)
						hit_idx = i;
				if (hit_idx >= 0) begin
					if (is_wr)
						shadow_dirty[hit_idx] = 1'b1;
					expect_word(sctd_pkg::EV_DONE, 1'b1, hit_idx, 1'b0, is_wr, '0, 1'b1);
				end else begin
					if (shadow_fill < ENTRY_COUNT) begin
						slot = shadow_fill;
						shadow_fill++;
					end else begin
						slot = shadow_victim;
						// dirty victim goes out first unless read-only drops it
						if (shadow_dirty[slot] && !shadow_ro)
							expect_word(sctd_pkg::EV_WB, 1'b0, slot, 1'b0, 1'b0,
								shadow_tag[slot], 1'b0);
						shadow_victim = (slot + 1) % ENTRY_COUNT;
					end
					shadow_tag[slot] = r.sector;
					shadow_dirty[slot] = is_wr;
					expect_word(sctd_pkg::EV_DONE, 1'b0, slot, !is_wr, is_wr, '0, 1'b1);
				end
			end
		end else if (r.kind == sctd_pkg::KIND_FLUSH) begin
			if (!shadow_ro)
				for (i = 0; i < shadow_fill; i++)
					if (shadow_dirty[i])
						expect_word(sctd_pkg::EV_WB, 1'b0, i, 1'b0, 1'b0, shadow_tag[i], 1'b0);
			for (i = 0; i < ENTRY_COUNT; i++)
				shadow_dirty[i] = 1'b0;
			shadow_fill = 0;
			shadow_victim = 0;
			expect_word(sctd_pkg::EV_DONE, 1'b0, 0, 1'b0, 1'b0, '0, 1'b1);
		end else begin
			expect_word(sctd_pkg::EV_DONE, 1'b0, 0, 1'b0, 1'b0, '0, 1'b1);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// random request: mostly a small pool of sectors so hits and evictions recur
	function automatic sector_req_t random_request();
		sector_req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			r.kind = sctd_pkg::KIND_READ;
		else if (pick < 95)
			r.kind = sctd_pkg::KIND_WRITE;
		else if (pick < 98)
			r.kind = sctd_pkg::KIND_FLUSH;
		else
			r.kind = KIND_SPARE;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			r.sector = pool_base + $urandom_range(0, 23);
		else if (pick < 85)
			r.sector = $urandom;
		else if (pick < 95)
			r.sector = shadow_limit - 32'd2 + $urandom_range(0, 3);
		else
			r.sector = pick[0] ? '1 : '0;
		return r;
	endfunction

	task automatic push_req(input logic [1:0] kind, input logic [31:0] sector);
		sector_req_t r;
		r.kind = kind;
		r.sector = sector;
		req_queue.insert(req_queue.size(), r);
	endtask

	// register write; only called with the block idle
	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sctd_pkg::CFG_READ_ONLY)
			shadow_ro = val[0];
		else
			shadow_limit = val;
		reg_writes++;
		@(negedge clk);
	endtask

	// wait until every request is taken and every owed word has arrived
	task automatic settle();
		while (req_queue.size() != 0 || s_tvalid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(input logic ro, input logic [31:0] limit, input logic [31:0] base,
			input int n, input bit gapless, input int sink, input bit long_hold);
		write_reg(sctd_pkg::CFG_READ_ONLY, {31'd0, ro});
		write_reg(sctd_pkg::CFG_SECTOR_LIMIT, limit);
		pool_base = base;
		sender_gapless = gapless;
		sink_mode = sink;
		if (long_hold)
			hold_asks++;
		repeat (n) req_queue.insert(req_queue.size(), random_request());
		settle();
	endtask

	// driver: offers queued requests in bursts, predicts each word taken
	sector_req_t offered;
	int          burst_left;
	int          gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(offered);
				reqs_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					offered = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, offered.sector, offered.kind};
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						if (sender_gapless || $urandom_range(0, 3) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, 7);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink: own stall pattern, plus a long hold-off on request
	int hold_left;
	int hold_served;
	int pattern_step;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			hold_served = 0;
			pattern_step = 0;
		end else begin
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				hold_left = HOLD_LEN;
			end
			pattern_step++;
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_FREE: m_tready <= 1'b1;
					SINK_RANDOM: m_tready <= ($urandom_range(0, 9) < 6);
					default: m_tready <= ((pattern_step % 7) < 4);
				endcase
			end
		end
	end

	// monitor: each word taken is checked against the oldest owed word
	always @(posedge clk) begin
		dir_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_checked++;
			if (due_results.size() == 0) begin
				$error("result word 0x%0h arrived with nothing outstanding", m_tdata);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				check_field("event_res", want.ev_code, m_tdata[1:0]);
				check_field("hit", want.hit, m_tdata[2]);
				check_field("entry", want.entry, m_tdata[6:3]);
				check_field("disk_read", want.disk_rd, m_tdata[7]);
				check_field("disk_write", want.disk_wr, m_tdata[8]);
				check_field("wb_sector", want.wb_sector, m_tdata[40:9]);
				check_field("last", want.is_last, m_tlast);
				check_field("padding", '0, m_tdata[47:41]);
				if (m_tdata[1:0] == sctd_pkg::EV_WB)
					wb_words++;
				if (m_tdata[2])
					hit_words++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("run stopped at the cycle limit, %0d words still owed", due_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: fills, out of range at the top sector, unused kind, flush with writebacks
		sink_mode = SINK_PATTERN;
		push_req(sctd_pkg::KIND_READ, 32'h0000_0000);
		push_req(sctd_pkg::KIND_WRITE, 32'hFFFF_FFFE);
		push_req(sctd_pkg::KIND_READ, 32'hFFFF_FFFF);
		push_req(sctd_pkg::KIND_WRITE, 32'h0000_0000);
		push_req(KIND_SPARE, 32'h1234_5678);
		push_req(sctd_pkg::KIND_FLUSH, 32'h0000_0000);
		for (int i = 0; i < ENTRY_COUNT; i++)
			push_req(sctd_pkg::KIND_WRITE, 32'd100 + i);
		push_req(sctd_pkg::KIND_WRITE, 32'd116);	// full: dirty victim written back
		settle();

		// read-only: write refused ahead of range check, dirty victim dropped, silent flush
		write_reg(sctd_pkg::CFG_READ_ONLY, 32'd1);
		push_req(sctd_pkg::KIND_WRITE, 32'hFFFF_FFFF);
		push_req(sctd_pkg::KIND_READ, 32'd117);
		push_req(sctd_pkg::KIND_FLUSH, 32'h0000_0000);
		settle();

		// zero limit rejects everything, then a limit of one
		write_reg(sctd_pkg::CFG_READ_ONLY, 32'd0);
		write_reg(sctd_pkg::CFG_SECTOR_LIMIT, 32'd0);
		push_req(sctd_pkg::KIND_READ, 32'd0);
		push_req(sctd_pkg::KIND_WRITE, 32'd0);
		settle();
		write_reg(sctd_pkg::CFG_SECTOR_LIMIT, 32'd1);
		push_req(sctd_pkg::KIND_READ, 32'd0);
		push_req(sctd_pkg::KIND_READ, 32'd1);
		push_req(sctd_pkg::KIND_WRITE, 32'd0);
		push_req(sctd_pkg::KIND_FLUSH, 32'hFFFF_FFFF);
		settle();

		// random phases across register settings and flow-control styles
		run_phase(1'b0, 32'hFFFF_FFFF, 32'h0000_1000, 60, 1'b0, SINK_RANDOM, 1'b0);
		run_phase(1'b0, 32'h8000_0000, 32'h7FFF_FFF0, 40, 1'b0, SINK_PATTERN, 1'b0);
		run_phase(1'b0, 32'hFFFF_FFFF, $urandom, 50, 1'b1, SINK_FREE, 1'b1);
		run_phase(1'b1, 32'hFFFF_FFFF, 32'h0000_2000, 40, 1'b0, SINK_RANDOM, 1'b0);
		run_phase(1'b0, 32'd1, 32'd0, 20, 1'b1, SINK_PATTERN, 1'b0);
		run_phase(1'b0, 32'd24, 32'd0, 50, 1'b0, SINK_RANDOM, 1'b0);
		run_phase(1'b1, 32'h0000_0010, 32'd0, 20, 1'b1, SINK_FREE, 1'b0);
		run_phase(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFE0, 40, 1'b0, SINK_RANDOM, 1'b0);

		repeat (20) @(negedge clk);
		$display("Took %0d requests over %0d register writes; checked %0d result words",
			reqs_taken, reg_writes, words_checked);
		$display("including %0d writebacks and %0d hits.", wb_words, hit_words);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
